// ===== sv/eedc_pkg.sv =====
// ----------------------------------------------------------------------------
// eedc_pkg
// Shared types and constants of the expiry evicting data cache.
// ----------------------------------------------------------------------------
package eedc_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int KEY_W   = 64;
  localparam int TIME_W  = 32;
  localparam int SIZE_W  = 16;
  localparam int HOP_W   = 8;
  localparam int TOTAL_W = 24;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

  localparam logic CMD_STORE = 1'b0;
  localparam logic CMD_AGE   = 1'b1;

  typedef enum logic [2:0] {
    OC_ADDED       = 3'd0,
    OC_UPDATED     = 3'd1,
    OC_EVICT_ADDED = 3'd2,
    OC_EXPIRED     = 3'd3,
    OC_SWEEP_DONE  = 3'd4,
    OC_SKIPPED     = 3'd5,
    OC_DROPPED     = 3'd6
  } outcome_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SWEEP,
    S_DECIDE,
    S_INSERT,
    S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic     start;
    logic     scan_run;
    logic     hops_wr;
    logic     evict;
    logic     insert;
    logic     set_outcome;
    outcome_t outcome;
    logic     emit_final;
  } eedc_cmd_t;

  typedef struct packed {
    logic is_age;
    logic is_here;
    logic scan_done;
    logic match;
    logic over_budget;
    logic victim_found;
    logic can_insert;
    logic evicted;
    logic out_free;
  } eedc_stat_t;

endpackage

// ===== sv/eedc_ctrl.sv =====
// ----------------------------------------------------------------------------
// eedc_ctrl
// Command sequencer: dispatch, slot scan, evict, insert and result transfer.
// ----------------------------------------------------------------------------
module eedc_ctrl
  import eedc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  eedc_stat_t stat,
  output eedc_cmd_t  ctl_cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl_cmd    = '0;
    in_stall   = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl_cmd.start = 1'b1;
          state_next    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.is_age) begin
          state_next = S_SWEEP;
        end else if (stat.is_here) begin
          ctl_cmd.set_outcome = 1'b1;
          ctl_cmd.outcome     = OC_SKIPPED;
          state_next          = S_FINISH;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl_cmd.scan_run = 1'b1;
        if (stat.scan_done) begin
          state_next = S_DECIDE;
        end
      end
      S_SWEEP: begin
        ctl_cmd.scan_run = 1'b1;
        if (stat.scan_done) begin
          ctl_cmd.set_outcome = 1'b1;
          ctl_cmd.outcome     = OC_SWEEP_DONE;
          state_next          = S_FINISH;
        end
      end
      S_DECIDE: begin
        if (stat.match) begin
          ctl_cmd.hops_wr     = 1'b1;
          ctl_cmd.set_outcome = 1'b1;
          ctl_cmd.outcome     = OC_UPDATED;
          state_next          = S_FINISH;
        end else begin
          ctl_cmd.evict = stat.over_budget && stat.victim_found;
          state_next    = S_INSERT;
        end
      end
      S_INSERT: begin
        ctl_cmd.set_outcome = 1'b1;
        if (stat.can_insert) begin
          ctl_cmd.insert  = 1'b1;
          ctl_cmd.outcome = stat.evicted ? OC_EVICT_ADDED : OC_ADDED;
        end else begin
          ctl_cmd.outcome = OC_DROPPED;
        end
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          ctl_cmd.emit_final = 1'b1;
          state_next         = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/eedc_dp.sv =====
// ----------------------------------------------------------------------------
// eedc_dp
// Slot storage, scan pipeline, byte accounting and the result register.
// ----------------------------------------------------------------------------
module eedc_dp
  import eedc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  eedc_cmd_t           ctl_cmd,
  output eedc_stat_t          stat,
  input  logic                cfg_write,
  input  logic [TOTAL_W-1:0]  cfg_data,
  input  logic                cmd,
  input  logic [KEY_W-1:0]    item_key,
  input  logic [TIME_W-1:0]   expiry_time,
  input  logic [SIZE_W-1:0]   packet_bytes,
  input  logic [HOP_W-1:0]    hop_count,
  input  logic                addressed_here,
  input  logic [TIME_W-1:0]   now_time,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          outcome,
  output logic [SIZE_W-1:0]   removed_bytes,
  output logic [TOTAL_W-1:0]  occupied_bytes,
  output logic                last_result
);

  // slot memories, read one row per cycle while the scan is not held
  logic [KEY_W-1:0]  mem_key    [DEPTH];
  logic [TIME_W-1:0] mem_expiry [DEPTH];
  logic [SIZE_W-1:0] mem_bytes  [DEPTH];
  logic [HOP_W-1:0]  mem_hops   [DEPTH];

  logic [DEPTH-1:0]   slot_valid;
  logic [TOTAL_W-1:0] max_bytes;
  logic [TOTAL_W-1:0] total;

  // latched item
  logic               is_age;
  logic               is_here;
  logic [KEY_W-1:0]   in_key;
  logic [TIME_W-1:0]  in_expiry;
  logic [SIZE_W-1:0]  in_bytes;
  logic [HOP_W-1:0]   in_hops;
  logic [TIME_W-1:0]  in_now;

  // scan pipeline
  logic [IDX_W-1:0]   rd_idx;
  logic               rd_busy;
  logic               ev_valid;
  logic [IDX_W-1:0]   ev_idx;
  logic [KEY_W-1:0]   rd_key;
  logic [TIME_W-1:0]  rd_expiry;
  logic [SIZE_W-1:0]  rd_bytes;

  // scan trackers
  logic               match_found;
  logic [IDX_W-1:0]   match_idx;
  logic               victim_found;
  logic [IDX_W-1:0]   victim_idx;
  logic [TIME_W-1:0]  victim_exp;
  logic [SIZE_W-1:0]  victim_bytes;
  logic               free_found;
  logic [IDX_W-1:0]   free_idx;
  logic               evicted;
  logic [SIZE_W-1:0]  ev_bytes;
  outcome_t           pend_outcome;

  logic               out_free;
  logic               ev_slot_valid;
  logic               sweep_hit;
  logic               hold;
  logic               advance;
  logic               sweep_emit;
  logic [IDX_W-1:0]   ins_idx;
  logic [TOTAL_W:0]   budget_sum;
  logic [TOTAL_W:0]   add_sum;
  logic [TOTAL_W-1:0] total_after_victim;
  logic [TOTAL_W-1:0] total_after_expire;
  logic [TOTAL_W-1:0] total_after_insert;
  outcome_t           out_code;

  assign out_free      = !out_valid || !out_stall;
  assign ev_slot_valid = slot_valid[ev_idx];
  assign sweep_hit     = is_age && ev_valid && ev_slot_valid && (rd_expiry < in_now);
  assign hold          = sweep_hit && !out_free;
  assign advance       = ctl_cmd.scan_run && !hold;
  assign sweep_emit    = ctl_cmd.scan_run && sweep_hit && out_free;

  assign ins_idx = (evicted && (!free_found || (victim_idx < free_idx))) ? victim_idx : free_idx;

  assign budget_sum = {1'b0, total} + {{(TOTAL_W + 1 - SIZE_W){1'b0}}, in_bytes};
  assign add_sum    = budget_sum;

  assign total_after_victim = ({{(TOTAL_W - SIZE_W){1'b0}}, victim_bytes} > total) ? '0 :
                              total - {{(TOTAL_W - SIZE_W){1'b0}}, victim_bytes};
  assign total_after_expire = ({{(TOTAL_W - SIZE_W){1'b0}}, rd_bytes} > total) ? '0 :
                              total - {{(TOTAL_W - SIZE_W){1'b0}}, rd_bytes};
  assign total_after_insert = add_sum[TOTAL_W] ? '1 : add_sum[TOTAL_W-1:0];

  always_comb begin
    stat              = '0;
    stat.is_age       = is_age;
    stat.is_here      = is_here;
    stat.scan_done    = ev_valid && (ev_idx == LAST_IDX) && !hold;
    stat.match        = match_found;
    stat.over_budget  = (max_bytes != '0) && (budget_sum > {1'b0, max_bytes});
    stat.victim_found = victim_found;
    stat.can_insert   = evicted || free_found;
    stat.evicted      = evicted;
    stat.out_free     = out_free;
  end

  // item capture and configuration
  always_ff @(posedge clk) begin
    if (ctl_cmd.start) begin
      is_age    <= (cmd == CMD_AGE);
      is_here   <= addressed_here;
      in_key    <= item_key;
      in_expiry <= expiry_time;
      in_bytes  <= packet_bytes;
      in_hops   <= hop_count;
      in_now    <= now_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes <= '0;
    end else if (cfg_write) begin
      max_bytes <= cfg_data;
    end
  end

  // memories: registered read at the scan pointer, writes from decide and insert
  always_ff @(posedge clk) begin
    if (advance) begin
      rd_key    <= mem_key[rd_idx];
      rd_expiry <= mem_expiry[rd_idx];
      rd_bytes  <= mem_bytes[rd_idx];
    end
    if (ctl_cmd.insert) begin
      mem_key[ins_idx]    <= in_key;
      mem_expiry[ins_idx] <= in_expiry;
      mem_bytes[ins_idx]  <= in_bytes;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_cmd.insert) begin
      mem_hops[ins_idx] <= in_hops;
    end else if (ctl_cmd.hops_wr) begin
      mem_hops[match_idx] <= in_hops;
    end
  end

  // scan pointer and result trackers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_busy      <= 1'b0;
      ev_valid     <= 1'b0;
      match_found  <= 1'b0;
      victim_found <= 1'b0;
      free_found   <= 1'b0;
      evicted      <= 1'b0;
    end else if (ctl_cmd.start) begin
      rd_idx       <= '0;
      rd_busy      <= 1'b1;
      ev_valid     <= 1'b0;
      match_found  <= 1'b0;
      victim_found <= 1'b0;
      free_found   <= 1'b0;
      evicted      <= 1'b0;
    end else begin
      if (advance) begin
        ev_valid <= rd_busy;
        ev_idx   <= rd_idx;
        if (rd_busy) begin
          if (rd_idx == LAST_IDX) begin
            rd_busy <= 1'b0;
          end else begin
            rd_idx <= rd_idx + 1'b1;
          end
        end
        if (ev_valid && !is_age) begin
          if (ev_slot_valid && (rd_key == in_key) && !match_found) begin
            match_found <= 1'b1;
            match_idx   <= ev_idx;
          end
          // strict compare keeps the lowest slot on equal expiry
          if (ev_slot_valid && (!victim_found || (rd_expiry < victim_exp))) begin
            victim_found <= 1'b1;
            victim_idx   <= ev_idx;
            victim_exp   <= rd_expiry;
            victim_bytes <= rd_bytes;
          end
          if (!ev_slot_valid && !free_found) begin
            free_found <= 1'b1;
            free_idx   <= ev_idx;
          end
        end
      end
      if (ctl_cmd.evict) begin
        evicted  <= 1'b1;
        ev_bytes <= victim_bytes;
      end
    end
  end

  // valid bits and byte total
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      total      <= '0;
    end else begin
      if (sweep_emit) begin
        slot_valid[ev_idx] <= 1'b0;
        total              <= total_after_expire;
      end else if (ctl_cmd.evict) begin
        slot_valid[victim_idx] <= 1'b0;
        total                  <= total_after_victim;
      end else if (ctl_cmd.insert) begin
        slot_valid[ins_idx] <= 1'b1;
        total               <= total_after_insert;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_cmd.set_outcome) begin
      pend_outcome <= ctl_cmd.outcome;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sweep_emit || ctl_cmd.emit_final) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sweep_emit) begin
      out_code       <= OC_EXPIRED;
      removed_bytes  <= rd_bytes;
      occupied_bytes <= total_after_expire;
      last_result    <= 1'b0;
    end else if (ctl_cmd.emit_final) begin
      out_code       <= pend_outcome;
      removed_bytes  <= (pend_outcome == OC_EVICT_ADDED) ? ev_bytes : '0;
      occupied_bytes <= total;
      last_result    <= 1'b1;
    end
  end

  assign outcome = out_code;

endmodule

// ===== sv/expiry_evicting_data_cache.sv =====
// ----------------------------------------------------------------------------
// expiry_evicting_data_cache
// Keyed item cache under a byte budget with earliest-expiry eviction and aging.
// ----------------------------------------------------------------------------
// a store that inserts or drops loads its result after the slot scan, which reads one row per
//   cycle for a store, then decide and insert; an update after scan and decide; one addressed here after dispatch
// an age sweep loads its final result after the sweep scan, plus output stalls
// one item at a time; the next item is accepted back in idle, once the final result
//   is loaded
// reset (rst, synchronous): all slots invalid, byte total and budget zero
module expiry_evicting_data_cache
  import eedc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [TOTAL_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic [KEY_W-1:0]   item_key,
  input  logic [TIME_W-1:0]  expiry_time,
  input  logic [SIZE_W-1:0]  packet_bytes,
  input  logic [HOP_W-1:0]   hop_count,
  input  logic               addressed_here,
  input  logic [TIME_W-1:0]  now_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         outcome,
  output logic [SIZE_W-1:0]  removed_bytes,
  output logic [TOTAL_W-1:0] occupied_bytes,
  output logic               last_result
);

  eedc_cmd_t  ctl_cmd;
  eedc_stat_t dp_stat;

  eedc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (dp_stat),
    .ctl_cmd  (ctl_cmd)
  );

  eedc_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl_cmd        (ctl_cmd),
    .stat           (dp_stat),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .item_key       (item_key),
    .expiry_time    (expiry_time),
    .packet_bytes   (packet_bytes),
    .hop_count      (hop_count),
    .addressed_here (addressed_here),
    .now_time       (now_time),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .outcome        (outcome),
    .removed_bytes  (removed_bytes),
    .occupied_bytes (occupied_bytes),
    .last_result    (last_result)
  );

endmodule
